### rtl/core/mbrptc_pkg.sv
// Package for the MBR partition table checker.
// Holds the transfer payload types, status codes and table constants.
// No dependencies.
`default_nettype none

package mbrptc_pkg;

    localparam int unsigned POS_W = 10;

    localparam logic [POS_W-1:0] TABLE_BASE   = 10'h1BE;
    localparam logic [POS_W-1:0] TABLE_END    = 10'h1FE;
    localparam logic [POS_W-1:0] SIG_LOW_POS  = 10'd510;
    localparam logic [POS_W-1:0] SIG_HIGH_POS = 10'd511;

    localparam logic [15:0] SIG_VALUE        = 16'hAA55;
    localparam logic [7:0]  TYPE_EMPTY       = 8'h00;
    localparam logic [7:0]  TYPE_GPT_PROTECT = 8'hEE;

    localparam logic [3:0] OFF_BOOT   = 4'd0;
    localparam logic [3:0] OFF_TYPE   = 4'd4;
    localparam logic [3:0] OFF_START0 = 4'd8;
    localparam logic [3:0] OFF_START3 = 4'd11;
    localparam logic [3:0] OFF_LEN0   = 4'd12;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_NOSIG   = 3'd2;
    localparam logic [2:0] ST_OVERLAP = 3'd3;
    localparam logic [2:0] ST_BEYOND  = 3'd4;

    localparam logic [1:0] LAST_ENTRY = 2'd3;

    typedef struct packed {
        logic [7:0] sector_byte;
        logic       truncated;
    } item_t;

    typedef struct packed {
        logic [1:0]  entry_index;
        logic [7:0]  boot_flag;
        logic [7:0]  part_type;
        logic [31:0] start_lba;
        logic [31:0] sector_count;
        logic [2:0]  status;
        logic        last;
    } result_t;

    typedef struct packed {
        logic       cap_en;
        logic       short_en;
        logic       sig_en;
        logic       judge_en;
        logic       emit_en;
        logic [1:0] emit_idx;
    } dp_cmd_t;

    typedef struct packed {
        logic pos_last;
    } dp_stat_t;

endpackage

`default_nettype wire

### rtl/core/mbrptc_ctrl.sv
// Controller state machine of the MBR partition table checker.
// Sequences byte collection, the table check and the four-entry emission.
// Depends on mbrptc_pkg.
`default_nettype none

module mbrptc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               truncated,
    input  wire mbrptc_pkg::dp_stat_t stat,
    output logic                    busy,
    output mbrptc_pkg::dp_cmd_t     cmd
);

    typedef enum logic [2:0] {
        S_COLLECT = 3'b001,
        S_CHECK   = 3'b010,
        S_EMIT    = 3'b100
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic       accept;

    assign busy   = (state_reg != S_COLLECT);
    assign accept = start && !busy;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.emit_idx = idx_reg;
        case (state_reg)
            S_COLLECT:
            begin
                if (accept)
                begin
                    if (truncated)
                    begin
                        cmd.short_en = 1'b1;
                    end
                    else if (stat.pos_last)
                    begin
                        cmd.sig_en = 1'b1;
                        state_next = S_CHECK;
                    end
                    else
                    begin
                        cmd.cap_en = 1'b1;
                    end
                end
            end
            S_CHECK:
            begin
                cmd.judge_en = 1'b1;
                idx_next     = 2'd0;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit_en = 1'b1;
                idx_next    = idx_reg + 2'd1;
                if (idx_reg == mbrptc_pkg::LAST_ENTRY)
                begin
                    state_next = S_COLLECT;
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
            idx_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mbrptc_dp.sv
// Datapath of the MBR partition table checker.
// Byte position, entry capture, signature, overlap and size checks, result register.
// Depends on mbrptc_pkg.
`default_nettype none

module mbrptc_dp (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [7:0]           sector_byte,
    input  wire logic [47:0]          disk_sectors,
    input  wire mbrptc_pkg::dp_cmd_t  cmd,
    output mbrptc_pkg::dp_stat_t      stat,
    output mbrptc_pkg::result_t       result,
    output logic                      result_strobe
);

    logic [mbrptc_pkg::POS_W-1:0] pos_reg;
    logic [mbrptc_pkg::POS_W-1:0] pos_next;
    logic [mbrptc_pkg::POS_W-1:0] rel_full;
    logic [1:0]                   rel_entry;
    logic [3:0]                   rel_off;
    logic                         in_table;

    logic [7:0]  boot_reg  [4];
    logic [7:0]  type_reg  [4];
    logic [31:0] start_reg [4];
    logic [31:0] len_reg   [4];
    logic [7:0]  sig_lo_reg;
    logic [7:0]  sig_hi_reg;
    logic [2:0]  status_reg;
    logic [2:0]  status_next;

    mbrptc_pkg::result_t result_reg;
    mbrptc_pkg::result_t result_next;
    logic                strobe_reg;
    logic                strobe_next;

    logic        chk     [4];
    logic [32:0] end_sum [4];
    logic        overlap;
    logic        beyond;

    assign stat.pos_last = (pos_reg == mbrptc_pkg::SIG_HIGH_POS);
    assign result        = result_reg;
    assign result_strobe = strobe_reg;

    assign rel_full  = pos_reg - mbrptc_pkg::TABLE_BASE;
    assign rel_entry = rel_full[5:4];
    assign rel_off   = rel_full[3:0];
    assign in_table  = (pos_reg >= mbrptc_pkg::TABLE_BASE) && (pos_reg < mbrptc_pkg::TABLE_END);

    always_comb
    begin
        pos_next = pos_reg;
        if (cmd.short_en || cmd.sig_en)
        begin
            pos_next = '0;
        end
        else if (cmd.cap_en)
        begin
            pos_next = pos_reg + 10'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            pos_reg    <= pos_next;
            strobe_reg <= strobe_next;
        end
    end

    // capture table fields and signature bytes
    always_ff @(posedge clk)
    begin
        if (cmd.cap_en)
        begin
            if (pos_reg == mbrptc_pkg::SIG_LOW_POS)
            begin
                sig_lo_reg <= sector_byte;
            end
            else if (in_table)
            begin
                if (rel_off == mbrptc_pkg::OFF_BOOT)
                begin
                    boot_reg[rel_entry] <= sector_byte;
                end
                else if (rel_off == mbrptc_pkg::OFF_TYPE)
                begin
                    type_reg[rel_entry] <= sector_byte;
                end
                else if (rel_off >= mbrptc_pkg::OFF_START0 && rel_off <= mbrptc_pkg::OFF_START3)
                begin
                    start_reg[rel_entry][8*rel_off[1:0] +: 8] <= sector_byte;
                end
                else if (rel_off >= mbrptc_pkg::OFF_LEN0)
                begin
                    len_reg[rel_entry][8*rel_off[1:0] +: 8] <= sector_byte;
                end
            end
        end
        if (cmd.sig_en)
        begin
            sig_hi_reg <= sector_byte;
        end
        status_reg <= status_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            chk[i]     = (type_reg[i] != mbrptc_pkg::TYPE_EMPTY) &&
                         (type_reg[i] != mbrptc_pkg::TYPE_GPT_PROTECT);
            end_sum[i] = {1'b0, start_reg[i]} + {1'b0, len_reg[i]};
        end
        overlap = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            for (int b = a + 1; b < 4; b++)
            begin
                if (chk[a] && chk[b] && ({1'b0, start_reg[a]} < end_sum[b]) &&
                    ({1'b0, start_reg[b]} < end_sum[a]))
                begin
                    overlap = 1'b1;
                end
            end
        end
        beyond = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            if (chk[i] && (disk_sectors < {15'd0, end_sum[i]}))
            begin
                beyond = 1'b1;
            end
        end
    end

    always_comb
    begin
        status_next = status_reg;
        if (cmd.judge_en)
        begin
            if ({sig_hi_reg, sig_lo_reg} != mbrptc_pkg::SIG_VALUE)
            begin
                status_next = mbrptc_pkg::ST_NOSIG;
            end
            else if (overlap)
            begin
                status_next = mbrptc_pkg::ST_OVERLAP;
            end
            else if (beyond)
            begin
                status_next = mbrptc_pkg::ST_BEYOND;
            end
            else
            begin
                status_next = mbrptc_pkg::ST_OK;
            end
        end
    end

    always_comb
    begin
        result_next = result_reg;
        strobe_next = 1'b0;
        if (cmd.short_en)
        begin
            result_next        = '0;
            result_next.status = mbrptc_pkg::ST_SHORT;
            result_next.last   = 1'b1;
            strobe_next        = 1'b1;
        end
        else if (cmd.emit_en)
        begin
            result_next.entry_index  = cmd.emit_idx;
            result_next.boot_flag    = boot_reg[cmd.emit_idx];
            result_next.part_type    = type_reg[cmd.emit_idx];
            result_next.start_lba    = start_reg[cmd.emit_idx];
            result_next.sector_count = len_reg[cmd.emit_idx];
            result_next.status       = status_reg;
            result_next.last         = (cmd.emit_idx == mbrptc_pkg::LAST_ENTRY);
            strobe_next              = 1'b1;
        end
    end

endmodule

`default_nettype wire

### rtl/core/mbr_partition_table_checker.sv
// MBR partition table checker, top level.
// Holds the disk size register behind the APB port; instantiates mbrptc_ctrl and mbrptc_dp.
// Depends on mbrptc_pkg.
//
// Feed the 512 bytes of the first sector one per cycle with start; a byte is taken
// whenever busy is low. After byte 511 busy stays high while the controller runs the
// signature, overlap and size checks and then reads out the entry registers, and the four
// entry results appear on consecutive cycles, each marked by result_strobe for one cycle.
// A byte with truncated set gives one short-sector result in the next cycle and restarts
// the count at offset 0. Results cannot be held off: capture each transfer in the
// cycle its strobe is high. Write disk_sectors only while no sector is in progress.
`default_nettype none

module mbr_partition_table_checker (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire mbrptc_pkg::item_t   item,
    output mbrptc_pkg::result_t      result,
    output logic                     result_strobe,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [63:0]         pwdata,
    output logic [63:0]              prdata,
    output logic                     pready
);

    logic [47:0]          disk_sectors_reg;
    logic [47:0]          disk_sectors_next;
    logic                 cfg_wr;
    mbrptc_pkg::dp_cmd_t  cmd;
    mbrptc_pkg::dp_stat_t stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[3];
    assign prdata = paddr[3] ? 64'd0 : {16'd0, disk_sectors_reg};

    always_comb
    begin
        disk_sectors_next = disk_sectors_reg;
        if (cfg_wr)
        begin
            disk_sectors_next = pwdata[47:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_sectors_reg <= '0;
        end
        else
        begin
            disk_sectors_reg <= disk_sectors_next;
        end
    end

    mbrptc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .truncated (item.truncated),
        .stat      (stat),
        .busy      (busy),
        .cmd       (cmd)
    );

    mbrptc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .sector_byte   (item.sector_byte),
        .disk_sectors  (disk_sectors_reg),
        .cmd           (cmd),
        .stat          (stat),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

`default_nettype wire
